FILE: src/mkd_pkg.sv
// Package for the Morse key decoder: payload structs, event codes, register
// indexes, reset values and the A-Z pattern table with its lookup function.
// Depends on nothing.
`default_nettype none

package mkd_pkg;

  localparam int MaxLettersDefault = 8;
  localparam int TimerBitsDefault  = 16;

  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 3;
  localparam int LettersW  = 4;
  localparam int CountW    = 3;
  localparam int SymbolsW  = 4;
  localparam int MaxSymbols = 4;
  localparam int CodeW     = 7;
  localparam int PosW      = 3;

  localparam logic [CfgDataW-1:0] DotLimitReset    = 16'd200;
  localparam logic [CfgDataW-1:0] DashLimitReset   = 16'd700;
  localparam logic [CfgDataW-1:0] LetterGapReset   = 16'd2000;
  localparam logic [CfgDataW-1:0] ControlLongReset = 16'd200;

  localparam logic [LettersW-1:0] LettersSat    = 4'hF;
  localparam logic [CodeW-1:0]    LetterUnknown = 7'h3F;
  localparam logic [CodeW-1:0]    LetterFirst   = 7'h41;

  typedef enum logic [2:0] {
    EvDot       = 3'd0,
    EvDash      = 3'd1,
    EvDecoded   = 3'd2,
    EvCancelled = 3'd3,
    EvCleared   = 3'd4,
    EvWordFull  = 3'd5
  } event_kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegDotLimit    = 3'd0,
    RegDashLimit   = 3'd1,
    RegLetterGap   = 3'd2,
    RegControlLong = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic key_level;
    logic control_level;
    logic help_level;
  } in_t;

  typedef struct packed {
    event_kind_e         event_kind;
    logic [CodeW-1:0]    letter_code;
    logic [PosW-1:0]     letter_position;
    logic [CountW-1:0]   symbol_count;
    logic [SymbolsW-1:0] symbol_bits;
  } out_t;

  localparam int NumLetters = 26;

  localparam logic [CountW-1:0] PatCount [NumLetters] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [SymbolsW-1:0] PatBits [NumLetters] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14,
    4'd5, 4'd2, 4'd3, 4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1,
    4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  function automatic logic [CodeW-1:0] decode_letter(logic [CountW-1:0] cnt,
                                                     logic [SymbolsW-1:0] bits);
    logic [SymbolsW-1:0] mask;
    logic [CodeW-1:0]    ch;
    mask = SymbolsW'((5'd1 << cnt) - 5'd1);
    ch   = LetterUnknown;
    for (int i = 0; i < NumLetters; i++) begin
      if (PatCount[i] == cnt && PatBits[i] == (bits & mask)) begin
        ch = LetterFirst + CodeW'(i);
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: src/morse_key_decoder.sv
// Morse key decoder top level: per-tick key, control and help handling with
// configuration registers and a registered result beat. Uses mkd_pkg.
//
// Channel   Direction  Handshake               Beat contents
// in        input      in_valid_i/in_ready_o    in_t: key, control, help levels
// out       output     out_valid_o/out_ready_i  out_t: event and letter state
// cfg       input      cfg_valid_i/cfg_ready_o  register index and 16-bit value
//
// Every input beat is processed in the cycle it is accepted; its result, if
// any, appears in the output register on the next cycle, so one beat per cycle
// is taken while the output register is empty or is being drained in the same
// cycle. Reset is asynchronous and restores the register defaults and cleared
// timers. Configuration writes are always taken.
`default_nettype none

module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_LETTERS = MaxLettersDefault,
  parameter int TIMER_BITS  = TimerBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int CmpW = (TIMER_BITS > CfgDataW) ? TIMER_BITS : CfgDataW;

  logic [CfgDataW-1:0] dot_limit_q, dash_limit_q, gap_limit_q, ctl_limit_q;

  logic [SymbolsW-1:0]   held_symbols_q, held_symbols_d;
  logic [CountW-1:0]     held_count_q, held_count_d;
  logic [LettersW-1:0]   letters_q, letters_d;
  logic [TIMER_BITS-1:0] key_timer_q, key_timer_d;
  logic [TIMER_BITS-1:0] gap_timer_q, gap_timer_d;
  logic [TIMER_BITS-1:0] ctl_timer_q, ctl_timer_d;
  logic                  prev_key_q, prev_ctl_q, prev_help_q;

  logic                  out_valid_q;
  out_t                  out_data_q, out_data_d;
  logic                  ev_valid;
  event_kind_e           ev_kind;
  logic [CodeW-1:0]      ev_code;
  logic [PosW-1:0]       ev_pos;
  logic                  in_accept;
  logic                  key_dash;

  logic k, c, h;

  assign k = in_data_i.key_level;
  assign c = in_data_i.control_level;
  assign h = in_data_i.help_level;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] t);
    return (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_limit_q  <= DotLimitReset;
      dash_limit_q <= DashLimitReset;
      gap_limit_q  <= LetterGapReset;
      ctl_limit_q  <= ControlLongReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDotLimit:    dot_limit_q  <= cfg_data_i;
        RegDashLimit:   dash_limit_q <= cfg_data_i;
        RegLetterGap:   gap_limit_q  <= cfg_data_i;
        RegControlLong: ctl_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl_timer_d    = c ? sat_inc(ctl_timer_q) : '0;
    key_timer_d    = k ? sat_inc(key_timer_q) : '0;
    gap_timer_d    = sat_inc(gap_timer_q);
    held_symbols_d = held_symbols_q;
    held_count_d   = held_count_q;
    letters_d      = letters_q;
    ev_valid       = 1'b0;
    ev_kind        = EvDot;
    ev_code        = '0;
    ev_pos         = '0;
    key_dash       = CmpW'(key_timer_q) >= CmpW'(dot_limit_q);

    if (prev_ctl_q && !c) begin
      held_symbols_d = '0;
      held_count_d   = '0;
      ev_valid       = 1'b1;
      if (CmpW'(ctl_timer_q) >= CmpW'(ctl_limit_q)) begin
        letters_d = '0;
        ev_kind   = EvCleared;
      end else begin
        ev_kind = EvCancelled;
      end
    end else if (h && !prev_help_q) begin
      held_symbols_d = '0;
      held_count_d   = '0;
      ev_valid       = 1'b1;
      ev_kind        = EvCancelled;
    end else if (k && !prev_key_q) begin
      if (letters_q >= LettersW'(MAX_LETTERS)) begin
        ev_valid = 1'b1;
        ev_kind  = EvWordFull;
      end
    end else if (!k && prev_key_q) begin
      if (letters_q < LettersW'(MAX_LETTERS) && held_count_q < CountW'(MaxSymbols) &&
          CmpW'(key_timer_q) < CmpW'(dash_limit_q)) begin
        held_symbols_d[held_count_q[1:0]] = key_dash;
        held_count_d = held_count_q + 1'b1;
        gap_timer_d  = '0;
        ev_valid     = 1'b1;
        ev_kind      = key_dash ? EvDash : EvDot;
      end
    end

    if (!ev_valid && !k && held_count_q != '0 &&
        CmpW'(gap_timer_d) >= CmpW'(gap_limit_q)) begin
      ev_code        = decode_letter(held_count_q, held_symbols_q);
      ev_pos         = letters_q[PosW-1:0];
      letters_d      = (letters_q < LettersSat) ? letters_q + 1'b1 : letters_q;
      held_symbols_d = '0;
      held_count_d   = '0;
      ev_valid       = 1'b1;
      ev_kind        = EvDecoded;
    end

    out_data_d.event_kind      = ev_kind;
    out_data_d.letter_code     = ev_code;
    out_data_d.letter_position = ev_pos;
    out_data_d.symbol_count    = held_count_d;
    out_data_d.symbol_bits     = held_symbols_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_symbols_q <= '0;
      held_count_q   <= '0;
      letters_q      <= '0;
      key_timer_q    <= '0;
      gap_timer_q    <= '0;
      ctl_timer_q    <= '0;
      prev_key_q     <= 1'b0;
      prev_ctl_q     <= 1'b0;
      prev_help_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        held_symbols_q <= held_symbols_d;
        held_count_q   <= held_count_d;
        letters_q      <= letters_d;
        key_timer_q    <= key_timer_d;
        gap_timer_q    <= gap_timer_d;
        ctl_timer_q    <= ctl_timer_d;
        prev_key_q     <= k;
        prev_ctl_q     <= c;
        prev_help_q    <= h;
        out_valid_q    <= ev_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && ev_valid) begin
      out_data_q <= out_data_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CountW'(MaxSymbols))
    else $error("Held symbol count exceeds four.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q)
    else $error("Input stalled with an empty output register.");

  a_event_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && ev_valid) |=> out_valid_q)
    else $error("Event was not registered for output.");

  a_symbol_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.event_kind == EvDot || out_data_q.event_kind == EvDash))
      |-> out_data_q.symbol_count != '0)
    else $error("Symbol event reported with no held symbols.");

  a_letter_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.event_kind == EvDecoded ||
                     out_data_q.event_kind == EvCancelled ||
                     out_data_q.event_kind == EvCleared))
      |-> (out_data_q.symbol_count == '0 && out_data_q.symbol_bits == '0))
    else $error("Letter end left symbols held.");

endmodule

`default_nettype wire

FILE: dv/mkd_checker.sv
// Checker for the Morse key decoder: watches the in, out and cfg channels,
// predicts every result beat from its own copy of the decoder state and
// compares it field by field. Uses mkd_pkg.

module mkd_checker
  import mkd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  in_t                       in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  out_t                      out_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  output int                        pending_o,
  output int                        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimerW = TimerBitsDefault;

  logic [CfgDataW-1:0] dot_lim, dash_lim, gap_lim, long_lim;
  logic [SymbolsW-1:0] held_bits;
  logic [CountW-1:0]   held_cnt;
  logic [LettersW-1:0] letters;
  logic [TimerW-1:0]   key_timer, gap_timer, ctl_timer;
  logic                last_key, last_ctl, last_help;

  out_t results_due[$];
  out_t want;
  int   mismatch_count = 0;
  int   waiting = 0;

  assign pending_o = waiting;
  assign errors_o  = mismatch_count;

  function automatic logic [TimerW-1:0] bump(logic [TimerW-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic logic [CodeW-1:0] morse_char(logic [CountW-1:0] cnt,
                                                  logic [SymbolsW-1:0] bits);
    logic [SymbolsW-1:0] used;
    logic [7:0]          ch;
    used = bits & ~(4'hF << cnt);
    case ({cnt, used})
      {3'd2, 4'd2}:  ch = "A";
      {3'd4, 4'd1}:  ch = "B";
      {3'd4, 4'd5}:  ch = "C";
      {3'd3, 4'd1}:  ch = "D";
      {3'd1, 4'd0}:  ch = "E";
      {3'd4, 4'd4}:  ch = "F";
      {3'd3, 4'd3}:  ch = "G";
      {3'd4, 4'd0}:  ch = "H";
      {3'd2, 4'd0}:  ch = "I";
      {3'd4, 4'd14}: ch = "J";
      {3'd3, 4'd5}:  ch = "K";
      {3'd4, 4'd2}:  ch = "L";
      {3'd2, 4'd3}:  ch = "M";
      {3'd2, 4'd1}:  ch = "N";
      {3'd3, 4'd7}:  ch = "O";
      {3'd4, 4'd6}:  ch = "P";
      {3'd4, 4'd11}: ch = "Q";
      {3'd3, 4'd2}:  ch = "R";
      {3'd3, 4'd0}:  ch = "S";
      {3'd1, 4'd1}:  ch = "T";
      {3'd3, 4'd4}:  ch = "U";
      {3'd4, 4'd8}:  ch = "V";
      {3'd3, 4'd6}:  ch = "W";
      {3'd4, 4'd9}:  ch = "X";
      {3'd4, 4'd13}: ch = "Y";
      {3'd4, 4'd3}:  ch = "Z";
      default:       ch = "?";
    endcase
    return ch[CodeW-1:0];
  endfunction

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp);
    if (got != exp) begin
      report($sformatf("%s got %0d expected %0d", name, got, exp));
    end
  endtask

  task automatic take_tick(input in_t b);
    logic [TimerW-1:0] ctl_len, key_len;
    logic              hit;
    out_t              res;
    ctl_len   = ctl_timer;
    key_len   = key_timer;
    hit       = 1'b0;
    res       = '0;
    ctl_timer = b.control_level ? bump(ctl_timer) : '0;
    key_timer = b.key_level ? bump(key_timer) : '0;
    gap_timer = bump(gap_timer);

    if (last_ctl && !b.control_level) begin
      held_bits = '0;
      held_cnt  = '0;
      hit       = 1'b1;
      if (ctl_len >= long_lim) begin
        letters        = '0;
        res.event_kind = EvCleared;
      end else begin
        res.event_kind = EvCancelled;
      end
    end else if (b.help_level && !last_help) begin
      held_bits      = '0;
      held_cnt       = '0;
      hit            = 1'b1;
      res.event_kind = EvCancelled;
    end else if (b.key_level && !last_key) begin
      if (letters >= MaxLettersDefault) begin
        hit            = 1'b1;
        res.event_kind = EvWordFull;
      end
    end else if (!b.key_level && last_key) begin
      if (letters < MaxLettersDefault && held_cnt < MaxSymbols && key_len < dash_lim) begin
        res.event_kind           = (key_len >= dot_lim) ? EvDash : EvDot;
        held_bits[held_cnt[1:0]] = (key_len >= dot_lim);
        held_cnt                 = held_cnt + 1'b1;
        gap_timer                = '0;
        hit                      = 1'b1;
      end
    end

    last_key  = b.key_level;
    last_ctl  = b.control_level;
    last_help = b.help_level;

    if (!hit && !b.key_level && held_cnt != 0 && gap_timer >= gap_lim) begin
      res.event_kind      = EvDecoded;
      res.letter_code     = morse_char(held_cnt, held_bits);
      res.letter_position = letters[PosW-1:0];
      if (letters != LettersSat) letters = letters + 1'b1;
      held_bits = '0;
      held_cnt  = '0;
      hit       = 1'b1;
    end

    if (hit) begin
      res.symbol_count = held_cnt;
      res.symbol_bits  = held_bits;
      results_due.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_lim   = DotLimitReset;
      dash_lim  = DashLimitReset;
      gap_lim   = LetterGapReset;
      long_lim  = ControlLongReset;
      held_bits = '0;
      held_cnt  = '0;
      letters   = '0;
      key_timer = '0;
      gap_timer = '0;
      ctl_timer = '0;
      last_key  = 1'b0;
      last_ctl  = 1'b0;
      last_help = 1'b0;
      results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report($sformatf("result beat of kind %0d with nothing expected",
                           int'(out_data_i.event_kind)));
        end else begin
          want = results_due.pop_front();
          check_field("event_kind", int'(out_data_i.event_kind), int'(want.event_kind));
          check_field("letter_code", int'(out_data_i.letter_code), int'(want.letter_code));
          check_field("letter_position", int'(out_data_i.letter_position),
                      int'(want.letter_position));
          check_field("symbol_count", int'(out_data_i.symbol_count),
                      int'(want.symbol_count));
          check_field("symbol_bits", int'(out_data_i.symbol_bits), int'(want.symbol_bits));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegDotLimit:    dot_lim  = cfg_data_i;
          RegDashLimit:   dash_lim = cfg_data_i;
          RegLetterGap:   gap_lim  = cfg_data_i;
          RegControlLong: long_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        take_tick(in_data_i);
      end
    end
    waiting = results_due.size();
  end

endmodule

FILE: dv/tb.sv
// Top of the Morse key decoder testbench: clock, reset, tick and register
// stimulus with random sender gaps and receiver stalls, watchdog and verdict.
// Uses mkd_pkg, morse_key_decoder and mkd_checker.

module tb
  import mkd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit     = 2000;
  localparam int HoldCycles     = 80;
  localparam int SettleCycles   = 8;
  localparam int RandomPerPhase = 140;
  localparam int NumPhases      = 5;
  localparam logic [CfgIndexW-1:0] RegFirstUnused = 3'd4;

  typedef enum int {SinkFree, SinkCoin, SinkMostly, SinkRhythm} sink_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  int pending, errors;
  int sent_count = 0;
  int burst_left = 0;
  int quiet = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int dot_cfg = DotLimitReset;
  int dash_cfg = DashLimitReset;
  int gap_cfg = LetterGapReset;
  int ctl_cfg = ControlLongReset;

  sink_mode_e sink_mode = SinkFree;
  int         sink_left = 0;
  int         sink_ticks = 0;

  morse_key_decoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  mkd_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i (in_ready_o),
    .in_data_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .out_data_i (out_data_o),
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served < holds_asked) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(SinkFree, SinkRhythm));
        sink_left = $urandom_range(20, 80);
      end else begin
        sink_left--;
      end
      sink_ticks++;
      case (sink_mode)
        SinkFree:   out_ready_i <= 1'b1;
        SinkCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        SinkMostly: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:    out_ready_i <= ((sink_ticks % 7) >= 2);
      endcase
    end
  end

  task automatic send_beat(input logic k, input logic c, input logic h);
    int gap_len;
    in_valid_i <= 1'b1;
    in_data_i  <= in_t'{key_level: k, control_level: c, help_level: h};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
      gap_len = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
  endtask

  task automatic hold_levels(input logic k, input logic c, input logic h, input int n);
    repeat (n) send_beat(k, c, h);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_settings(input int dot, input int dash, input int gap, input int ctl);
    put_reg(RegDotLimit, CfgDataW'(dot));
    put_reg(RegDashLimit, CfgDataW'(dash));
    put_reg(RegLetterGap, CfgDataW'(gap));
    put_reg(RegControlLong, CfgDataW'(ctl));
    put_reg(RegFirstUnused | CfgIndexW'($urandom_range(0, 3)), CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
    dot_cfg  = dot;
    dash_cfg = dash;
    gap_cfg  = gap;
    ctl_cfg  = ctl;
  endtask

  function automatic int press_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && dot_cfg > 1) begin
      return $urandom_range(1, (dot_cfg > 10) ? 10 : dot_cfg - 1);
    end
    if (r < 9 && dash_cfg > dot_cfg && dot_cfg <= 10) begin
      return $urandom_range(dot_cfg, (dash_cfg - 1 > dot_cfg + 8) ? dot_cfg + 8 : dash_cfg - 1);
    end
    if (dash_cfg <= 10) begin
      return $urandom_range(dash_cfg, dash_cfg + 2);
    end
    return $urandom_range(1, 10);
  endfunction

  task automatic send_letter();
    int nsym, space;
    nsym = ($urandom_range(0, 7) == 0) ? 5 : $urandom_range(1, 4);
    repeat (nsym) begin
      hold_levels(1'b1, 1'b0, 1'b0, press_len());
      space = (gap_cfg > 2) ? $urandom_range(1, (gap_cfg > 4) ? 3 : gap_cfg - 1) : 1;
      hold_levels(1'b0, 1'b0, 1'b0, space);
    end
    hold_levels(1'b0, 1'b0, 1'b0,
                (gap_cfg <= 8) ? gap_cfg + $urandom_range(0, 2) : $urandom_range(1, 4));
  endtask

  task automatic run_random(input int budget);
    int stop_at, pick;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_letter();
      end else if (pick < 16) begin
        hold_levels(1'b0, 1'b1, 1'b0,
                    (ctl_cfg <= 8) ? $urandom_range(1, ctl_cfg + 2) : $urandom_range(1, 8));
        hold_levels(1'b0, 1'b0, 1'b0, 1);
      end else if (pick == 16) begin
        hold_levels(1'b0, 1'b0, 1'b1, $urandom_range(1, 3));
        hold_levels(1'b0, 1'b0, 1'b0, 1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    int dots[NumPhases]  = '{2, 1, 3, 65535, 3};
    int dashes[NumPhases] = '{5, 1, 65535, 65535, 7};
    int gaps[NumPhases]  = '{3, 1, 2, 65535, 4};
    int ctls[NumPhases]  = '{3, 1, 65535, 2, 5};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register defaults give a dot for a one-tick press and a cancel
    // for a short control press.
    hold_levels(1'b1, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    settle();

    write_settings(2, 4, 1, 3);
    hold_levels(1'b1, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 2);
    hold_levels(1'b1, 1'b0, 1'b0, 3);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    // A press past the dash limit is dropped and the letter still decodes.
    hold_levels(1'b1, 1'b0, 1'b0, 5);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    // The fifth symbol of a letter is dropped.
    repeat (5) begin
      hold_levels(1'b1, 1'b0, 1'b0, 1);
      hold_levels(1'b0, 1'b0, 1'b0, 1);
    end
    hold_levels(1'b1, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b1, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    hold_levels(1'b1, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    hold_levels(1'b1, 1'b1, 1'b0, 3);
    hold_levels(1'b1, 1'b0, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);
    // A control release wins over a help press in the same tick.
    hold_levels(1'b0, 1'b1, 1'b0, 1);
    hold_levels(1'b0, 1'b0, 1'b1, 1);
    hold_levels(1'b0, 1'b0, 1'b0, 1);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_settings(dots[p], dashes[p], gaps[p], ctls[p]);
      if (p == 0) holds_asked++;
      run_random(RandomPerPhase);
    end
    settle();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: morse_key_decoder.f
src/mkd_pkg.sv
src/morse_key_decoder.sv
dv/mkd_checker.sv
dv/tb.sv
